/* design/lcc_pkg.sv */
// Shared constants, types and helper function of the Lehmer code converter.
package lcc_pkg;

  localparam int MaxLen = 64;
  localparam int PosW   = 6;
  localparam int CntW   = 7;
  localparam int NumLvl = 6;
  localparam int LvlW   = 3;

  typedef struct packed {
    logic            load;    // latch a new request, reload flags when first is set
    logic            step;    // walk one level of the count tree
    logic [LvlW-1:0] lvl;     // tree level of the children looked at in this step
    logic            commit;  // register the result and update the flags
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_sts_t;

  // Number of available positions below a node after a reload to length len.
  function automatic logic [CntW-1:0] node_init(input logic [CntW-1:0] len, input int lv,
                                                input int idx);
    int lo;
    int size;
    int n;
    lo   = idx * (1 << lv);
    size = 1 << lv;
    n    = int'(len) - lo;
    if (n <= 0) begin
      return '0;
    end else if (n >= size) begin
      return CntW'(size);
    end else begin
      return CntW'(n);
    end
  endfunction

endpackage

/* design/lcc_ctrl.sv */
// Controller of the Lehmer code converter: accept, tree walk and commit sequencing.
module lcc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic             m_tready_i,
  input  lcc_pkg::dp_sts_t sts_i,
  output lcc_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [lcc_pkg::LvlW-1:0] lvl_q, lvl_d;
  logic                    accept;
  logic                    commit;

  assign s_tready_o = (state_q == StIdle);
  assign accept     = s_tvalid_i && s_tready_o;
  assign commit     = (state_q == StDone) && (!sts_i.out_full || m_tready_i);

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StWalk;
          lvl_d   = lcc_pkg::LvlW'(lcc_pkg::NumLvl - 1);
        end
      end
      StWalk: begin
        if (lvl_q == '0) begin
          state_d = StDone;
        end else begin
          lvl_d = lvl_q - lcc_pkg::LvlW'(1);
        end
      end
      StDone: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

  assign cmd_o.load   = accept;
  assign cmd_o.step   = (state_q == StWalk);
  assign cmd_o.lvl    = lvl_q;
  assign cmd_o.commit = commit;

  // A request always starts its walk at the top of the tree.
  a_load_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StWalk) && (lvl_q == lcc_pkg::LvlW'(lcc_pkg::NumLvl - 1)))
    else $error("walk did not start at the top level");

  // The walk ends in the commit state after the leaf level.
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) && (lvl_q == '0) |=> (state_q == StDone))
    else $error("walk did not end in commit state");

endmodule

/* design/lcc_datapath.sv */
// Datapath of the Lehmer code converter: flags, count tree, walker and result register.
module lcc_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lcc_pkg::dp_cmd_t          cmd_i,
  output lcc_pkg::dp_sts_t          sts_o,
  input  logic                      func_i,
  input  logic                      first_i,
  input  logic [lcc_pkg::PosW-1:0]  value_i,
  input  logic [lcc_pkg::CntW-1:0]  perm_length_i,
  input  logic                      m_tready_i,
  output logic                      out_valid_o,
  output logic [lcc_pkg::PosW-1:0]  result_o,
  output logic                      invalid_o
);

  // Count tree: level L node i holds the number of available positions in
  // [i * 2^L, (i + 1) * 2^L). The leaves are the availability flags.
  logic [63:0]             avail_q;
  logic [1:0]              lvl1_q [32];
  logic [2:0]              lvl2_q [16];
  logic [3:0]              lvl3_q [8];
  logic [4:0]              lvl4_q [4];
  logic [5:0]              lvl5_q [2];
  logic [lcc_pkg::CntW-1:0] root_q;

  logic                    func_q;
  logic [lcc_pkg::PosW-1:0] val_q;
  logic                    bad_q;
  logic [lcc_pkg::PosW-1:0] work_q;
  logic [lcc_pkg::PosW-1:0] pos_q;

  logic                    out_valid_q;
  logic [lcc_pkg::PosW-1:0] res_q;
  logic                    inv_q;

  logic [lcc_pkg::CntW-1:0] len_sat;
  logic                    enc_ok;
  logic                    dec_ok;
  logic                    reload;
  logic                    clear;
  logic [lcc_pkg::CntW-1:0] left_cnt;
  logic                    take;

  assign len_sat = (perm_length_i > lcc_pkg::CntW'(lcc_pkg::MaxLen)) ?
                   lcc_pkg::CntW'(lcc_pkg::MaxLen) : perm_length_i;

  // Validity is judged on the flags as they stand after a possible reload.
  assign enc_ok = ({1'b0, value_i} < lcc_pkg::CntW'(lcc_pkg::MaxLen)) &&
                  (first_i ? ({1'b0, value_i} < len_sat) : avail_q[value_i]);
  assign dec_ok = {1'b0, value_i} < (first_i ? len_sat : root_q);

  assign reload = cmd_i.load && first_i;
  assign clear  = cmd_i.commit && !bad_q;

  // Left child of the current node; the bit of pos_q at this level is still zero.
  always_comb begin
    case (cmd_i.lvl)
      3'd0:    left_cnt = lcc_pkg::CntW'(avail_q[pos_q]);
      3'd1:    left_cnt = lcc_pkg::CntW'(lvl1_q[pos_q[5:1]]);
      3'd2:    left_cnt = lcc_pkg::CntW'(lvl2_q[pos_q[5:2]]);
      3'd3:    left_cnt = lcc_pkg::CntW'(lvl3_q[pos_q[5:3]]);
      3'd4:    left_cnt = lcc_pkg::CntW'(lvl4_q[pos_q[5:4]]);
      3'd5:    left_cnt = lcc_pkg::CntW'(lvl5_q[pos_q[5]]);
      default: left_cnt = '0;
    endcase
  end

  assign take = func_q ? ({1'b0, work_q} >= left_cnt) : val_q[cmd_i.lvl];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '1;
      for (int i = 0; i < 32; i++) lvl1_q[i] <= 2'(lcc_pkg::node_init(7'd64, 1, i));
      for (int i = 0; i < 16; i++) lvl2_q[i] <= 3'(lcc_pkg::node_init(7'd64, 2, i));
      for (int i = 0; i < 8; i++)  lvl3_q[i] <= 4'(lcc_pkg::node_init(7'd64, 3, i));
      for (int i = 0; i < 4; i++)  lvl4_q[i] <= 5'(lcc_pkg::node_init(7'd64, 4, i));
      for (int i = 0; i < 2; i++)  lvl5_q[i] <= 6'(lcc_pkg::node_init(7'd64, 5, i));
      root_q <= lcc_pkg::CntW'(lcc_pkg::MaxLen);
    end else if (reload) begin
      for (int i = 0; i < 64; i++) avail_q[i] <= (i < int'(len_sat));
      for (int i = 0; i < 32; i++) lvl1_q[i] <= 2'(lcc_pkg::node_init(len_sat, 1, i));
      for (int i = 0; i < 16; i++) lvl2_q[i] <= 3'(lcc_pkg::node_init(len_sat, 2, i));
      for (int i = 0; i < 8; i++)  lvl3_q[i] <= 4'(lcc_pkg::node_init(len_sat, 3, i));
      for (int i = 0; i < 4; i++)  lvl4_q[i] <= 5'(lcc_pkg::node_init(len_sat, 4, i));
      for (int i = 0; i < 2; i++)  lvl5_q[i] <= 6'(lcc_pkg::node_init(len_sat, 5, i));
      root_q <= len_sat;
    end else if (clear) begin
      // Mark the position used and take one off every node on its path.
      avail_q[pos_q]         <= 1'b0;
      lvl1_q[pos_q[5:1]]     <= lvl1_q[pos_q[5:1]] - 2'd1;
      lvl2_q[pos_q[5:2]]     <= lvl2_q[pos_q[5:2]] - 3'd1;
      lvl3_q[pos_q[5:3]]     <= lvl3_q[pos_q[5:3]] - 4'd1;
      lvl4_q[pos_q[5:4]]     <= lvl4_q[pos_q[5:4]] - 5'd1;
      lvl5_q[pos_q[5]]       <= lvl5_q[pos_q[5]] - 6'd1;
      root_q                 <= root_q - lcc_pkg::CntW'(1);
    end
  end

  // Request and walker registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      val_q  <= value_i;
      bad_q  <= !(func_i ? dec_ok : enc_ok);
      work_q <= func_i ? value_i : '0;
      pos_q  <= '0;
    end else if (cmd_i.step) begin
      pos_q[cmd_i.lvl] <= take;
      if (take) begin
        // Decode drops the skipped count from the digit; encode adds it to the rank.
        work_q <= func_q ? (work_q - left_cnt[lcc_pkg::PosW-1:0])
                         : (work_q + left_cnt[lcc_pkg::PosW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= bad_q ? '0 : (func_q ? pos_q : work_q);
      inv_q <= bad_q;
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign result_o       = res_q;
  assign invalid_o      = inv_q;

  // The count tree root always matches the number of set flags.
  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(avail_q) == int'(root_q))
    else $error("root count differs from flag population");

  // A commit never overwrites a result the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten");

  // A request that is not rejected takes exactly one position at its commit.
  a_one_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (root_q == $past(root_q) - lcc_pkg::CntW'(1)))
    else $error("commit did not remove exactly one position");

endmodule

/* design/lehmer_code_converter.sv */
// Top level of the Lehmer code converter: stream ports, config register, controller, datapath.
//
// Usage: each request on the slave stream converts one permutation element.
// tuser selects encode (0: value to Lehmer digit) or decode (1: digit to
// value); tlast marks the first element of a new permutation and reloads
// the availability flags for the configured length before the element is
// processed. Each request yields exactly one result on the master stream:
// the digit or value in tdata and an invalid flag in tuser. A rejected
// request returns zero with the flag set and takes no position, though a
// first element still reloads the availability flags. A request walks the
// six-level count tree from the top, one level per cycle, and then commits:
// it updates the flags and registers its result. The next request is
// accepted once that result is registered. If the receiver stalls, one
// finished result waits in the output register while the next request is
// still accepted and worked on; its commit then holds until the register
// is free. Reset sets the length to 64 with all positions available. A
// length write takes effect at the next first element.
module lehmer_code_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,        // perm_length
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,    // [5:0] value, [7:6] zero
  input  logic       s_axis_tuser_i,    // [0] func
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,    // [5:0] result, [7:6] zero
  output logic       m_axis_tuser_o     // [0] invalid
);

  logic [lcc_pkg::CntW-1:0] perm_length_q;
  lcc_pkg::dp_cmd_t         cmd;
  lcc_pkg::dp_sts_t         sts;
  logic [lcc_pkg::PosW-1:0] result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_length_q <= lcc_pkg::CntW'(lcc_pkg::MaxLen);
    end else if (cfg_valid_i) begin
      perm_length_q <= cfg_data_i;
    end
  end

  lcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tuser_i),
    .first_i       (s_axis_tlast_i),
    .value_i       (s_axis_tdata_i[5:0]),
    .perm_length_i (perm_length_q),
    .m_tready_i    (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .result_o      (result),
    .invalid_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, result};

endmodule
